FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the project.
// Depends on nothing; included by the file that holds assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lfmd_pkg.sv
// Shared types and constants of the Manchester uplink decoder.
// Depends on nothing; used by all decoder modules.
package lfmd_pkg;

	localparam int FrameBytesDefault = 8;
	localparam int CntW = 17;
	localparam logic [CntW-1:0] CntMax = '1;

	localparam logic [15:0] SyncMinHighRst = 16'd700;
	localparam logic [7:0]  SyncAttemptsRst = 8'd50;
	localparam logic [15:0] FirstDelayRst = 16'd650;
	localparam logic [15:0] BitDelayRst = 16'd350;
	localparam logic [16:0] EdgeTimeoutRst = 17'd7200;
	localparam logic [16:0] StartTimeoutRst = 17'd72000;

	// Register indexes (byte address divided by four).
	typedef enum logic [2:0] {
		REG_SYNC_MIN_HIGH = 3'd0,
		REG_SYNC_ATTEMPTS = 3'd1,
		REG_FIRST_DELAY   = 3'd2,
		REG_BIT_DELAY     = 3'd3,
		REG_EDGE_TIMEOUT  = 3'd4,
		REG_START_TIMEOUT = 3'd5,
		REG_SPARE6        = 3'd6,
		REG_SPARE7        = 3'd7
	} reg_idx_t;

	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_HUNT_LOW  = 7'b0000010,
		PH_HUNT_HIGH = 7'b0000100,
		PH_WAIT_LOW  = 7'b0001000,
		PH_WAIT_HIGH = 7'b0010000,
		PH_DELAY     = 7'b0100000,
		PH_EDGE      = 7'b1000000
	} phase_t;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [15:0] sync_min_high;
		logic [7:0]  sync_attempts;
		logic [15:0] first_sample_delay;
		logic [15:0] bit_sample_delay;
		logic [16:0] edge_timeout;
		logic [16:0] start_timeout;
	} cfg_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [2:0] byte_index;
		logic       status;
		logic       last;
	} result_t;

	function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
		return (c == CntMax) ? CntMax : c + 1'b1;
	endfunction

endpackage

FILE: sv/lfmd_regs.sv
// APB configuration registers of the Manchester uplink decoder.
// Depends on lfmd_pkg for the register indexes, reset values and cfg_t.
module lfmd_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output lfmd_pkg::cfg_t      cfg
);

	lfmd_pkg::cfg_t   cfg_q;
	lfmd_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx = lfmd_pkg::reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_min_high      <= lfmd_pkg::SyncMinHighRst;
			cfg_q.sync_attempts      <= lfmd_pkg::SyncAttemptsRst;
			cfg_q.first_sample_delay <= lfmd_pkg::FirstDelayRst;
			cfg_q.bit_sample_delay   <= lfmd_pkg::BitDelayRst;
			cfg_q.edge_timeout       <= lfmd_pkg::EdgeTimeoutRst;
			cfg_q.start_timeout      <= lfmd_pkg::StartTimeoutRst;
		end else if (wr_en) begin
			unique case (idx)
				lfmd_pkg::REG_SYNC_MIN_HIGH: cfg_q.sync_min_high <= pwdata[15:0];
				lfmd_pkg::REG_SYNC_ATTEMPTS: cfg_q.sync_attempts <= pwdata[7:0];
				lfmd_pkg::REG_FIRST_DELAY:   cfg_q.first_sample_delay <= pwdata[15:0];
				lfmd_pkg::REG_BIT_DELAY:     cfg_q.bit_sample_delay <= pwdata[15:0];
				lfmd_pkg::REG_EDGE_TIMEOUT:  cfg_q.edge_timeout <= pwdata[16:0];
				lfmd_pkg::REG_START_TIMEOUT: cfg_q.start_timeout <= pwdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lfmd_pkg::REG_SYNC_MIN_HIGH: prdata = {16'd0, cfg_q.sync_min_high};
			lfmd_pkg::REG_SYNC_ATTEMPTS: prdata = {24'd0, cfg_q.sync_attempts};
			lfmd_pkg::REG_FIRST_DELAY:   prdata = {16'd0, cfg_q.first_sample_delay};
			lfmd_pkg::REG_BIT_DELAY:     prdata = {16'd0, cfg_q.bit_sample_delay};
			lfmd_pkg::REG_EDGE_TIMEOUT:  prdata = {15'd0, cfg_q.edge_timeout};
			lfmd_pkg::REG_START_TIMEOUT: prdata = {15'd0, cfg_q.start_timeout};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

FILE: sv/lfmd_core.sv
// Sync hunt, edge timing and Manchester bit assembly of the uplink decoder.
// Depends on lfmd_pkg for the phase encoding, cfg_t, result_t and bump().
module lfmd_core #(
	parameter int FRAME_BYTES = lfmd_pkg::FrameBytesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lfmd_pkg::cfg_t      cfg,
	input  logic                step,
	input  logic                command,
	input  logic                level,
	output logic                res_valid,
	output lfmd_pkg::result_t   res
);

	localparam logic [3:0] FrameLen = 4'(FRAME_BYTES);

	lfmd_pkg::phase_t phase_q, phase_n;
	logic [16:0] tick_q, tick_n, miss;
	logic [7:0]  att_q, att_n;
	logic [5:0]  bit_q, bit_n;
	logic [7:0]  shift_q, shift_n, shift_in;
	logic        held_q, held_n;
	logic        fin;

	assign miss = lfmd_pkg::bump(tick_q);
	assign shift_in = {shift_q[6:0], held_q};
	assign fin = ({1'b0, bit_q[5:3]} + 4'd1) >= FrameLen;

	always_comb begin
		phase_n = phase_q;
		tick_n = tick_q;
		att_n = att_q;
		bit_n = bit_q;
		shift_n = shift_q;
		held_n = held_q;
		res_valid = 1'b0;
		res.byte_value = 8'd0;
		res.byte_index = 3'd0;
		res.status = lfmd_pkg::STATUS_TIMEOUT;
		res.last = 1'b1;
		if (command) begin
			phase_n = lfmd_pkg::PH_HUNT_LOW;
			tick_n = '0;
			att_n = '0;
			bit_n = '0;
			shift_n = '0;
			held_n = 1'b0;
		end else begin
			unique case (phase_q)
				lfmd_pkg::PH_IDLE: begin
				end
				lfmd_pkg::PH_HUNT_LOW: begin
					if (level) begin
						if (cfg.sync_min_high <= 16'd1) begin
							phase_n = lfmd_pkg::PH_WAIT_LOW;
							tick_n = '0;
						end else begin
							phase_n = lfmd_pkg::PH_HUNT_HIGH;
							tick_n = 17'd1;
						end
					end else begin
						tick_n = miss;
						if (miss >= cfg.edge_timeout) begin
							res_valid = 1'b1;
						end
					end
				end
				lfmd_pkg::PH_HUNT_HIGH: begin
					if (level) begin
						tick_n = miss;
						if (miss >= {1'b0, cfg.sync_min_high}) begin
							phase_n = lfmd_pkg::PH_WAIT_LOW;
							tick_n = '0;
						end
					end else begin
						att_n = (att_q == 8'hFF) ? att_q : att_q + 8'd1;
						phase_n = (att_n >= cfg.sync_attempts) ? lfmd_pkg::PH_WAIT_HIGH
							: lfmd_pkg::PH_HUNT_LOW;
						tick_n = '0;
					end
				end
				lfmd_pkg::PH_WAIT_LOW: begin
					if (!level) begin
						phase_n = lfmd_pkg::PH_WAIT_HIGH;
						tick_n = '0;
					end else begin
						tick_n = miss;
						if (miss >= cfg.edge_timeout) begin
							res_valid = 1'b1;
						end
					end
				end
				lfmd_pkg::PH_WAIT_HIGH: begin
					if (level) begin
						phase_n = lfmd_pkg::PH_DELAY;
						tick_n = {1'b0, cfg.first_sample_delay};
						bit_n = '0;
						shift_n = '0;
					end else begin
						tick_n = miss;
						if (miss >= cfg.start_timeout) begin
							res_valid = 1'b1;
						end
					end
				end
				lfmd_pkg::PH_DELAY: begin
					if (tick_q != '0) begin
						tick_n = tick_q - 17'd1;
					end else begin
						held_n = level;
						phase_n = lfmd_pkg::PH_EDGE;
					end
				end
				lfmd_pkg::PH_EDGE: begin
					if (level != held_q) begin
						bit_n = bit_q + 6'd1;
						phase_n = lfmd_pkg::PH_DELAY;
						tick_n = {1'b0, cfg.bit_sample_delay};
						shift_n = shift_in;
						if (bit_q[2:0] == 3'd7) begin
							res_valid = 1'b1;
							res.byte_value = shift_in;
							res.byte_index = bit_q[5:3];
							res.status = lfmd_pkg::STATUS_OK;
							res.last = fin;
							shift_n = '0;
							if (fin) begin
								phase_n = lfmd_pkg::PH_IDLE;
								tick_n = '0;
							end
						end
					end else begin
						tick_n = miss;
						if (miss >= cfg.edge_timeout) begin
							res_valid = 1'b1;
							res.byte_index = bit_q[5:3];
						end
					end
				end
				default: begin
					phase_n = lfmd_pkg::PH_IDLE;
				end
			endcase
			// A timeout sends the block back to idle.
			if (res_valid && res.status == lfmd_pkg::STATUS_TIMEOUT) begin
				phase_n = lfmd_pkg::PH_IDLE;
				tick_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lfmd_pkg::PH_IDLE;
			tick_q <= '0;
			att_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			held_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			tick_q <= tick_n;
			att_q <= att_n;
			bit_q <= bit_n;
			shift_q <= shift_n;
			held_q <= held_n;
		end
	end

endmodule

FILE: sv/lfmd_out.sv
// Output word register of the uplink decoder, decoupling it from the sink.
// Depends on lfmd_pkg for result_t.
module lfmd_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  lfmd_pkg::result_t   res,
	output logic                free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,
	output logic [0:0]          m_tuser,
	output logic                m_tlast
);

	logic              valid_q;
	lfmd_pkg::result_t res_q;

	assign free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata = {5'd0, res_q.byte_index, res_q.byte_value};
	assign m_tuser = res_q.status;
	assign m_tlast = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

FILE: sv/lf_rfid_manchester_uplink_decoder.sv
// Top level of the 125 kHz tag uplink Manchester decoder.
// Depends on lfmd_pkg, lfmd_regs, lfmd_core and lfmd_out.
//
// The decoder takes one word per microsecond tick on the slave stream: tuser
// carries the command (low for a sample tick, high to start a reception) and
// tdata bit 0 carries the demodulated tag level. After a start it hunts for a
// sync, a high level of at least sync_min_high ticks; after sync_attempts
// short pulses it gives up hunting and proceeds anyway. It then waits for a
// low and a high level, lets first_sample_delay ticks pass and reads
// FRAME_BYTES*8 Manchester bits, each bit being the level held before the
// mid-bit edge, with bit_sample_delay ticks after every edge. Every completed
// byte leaves on the master stream, first bit in the MSB, with its frame
// index; tlast marks the final byte. An edge wait that runs past
// edge_timeout (or start_timeout for the start high) sends one word with
// tuser high and tlast high, and the decoder goes idle. A start during a
// reception restarts it. Each word is processed by the tick logic, which
// runs combinationally between the state registers and the output word
// register, so a word is accepted every cycle while the output register is
// empty or being drained. The six registers sit at byte addresses 0x00 to
// 0x14 of the APB port; write them only while the decoder is idle.
module lf_rfid_manchester_uplink_decoder #(
	parameter int FRAME_BYTES = lfmd_pkg::FrameBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Tick stream in.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] level, [7:1] zero
	input  logic [0:0]  s_tuser,   // [0] command
	// Byte stream out.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] byte_value, [10:8] byte_index, [15:11] zero
	output logic [0:0]  m_tuser,   // [0] status
	output logic        m_tlast    // last
);

	lfmd_pkg::cfg_t    cfg;
	lfmd_pkg::result_t res;
	logic              res_valid;
	logic              step;
	logic              out_free;

	// A word is taken whenever the output register can take a result.
	assign s_tready = out_free;
	assign step = s_tvalid & s_tready;

	lfmd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lfmd_core #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.command   (s_tuser[0]),
		.level     (s_tdata[0]),
		.res_valid (res_valid),
		.res       (res)
	);

	lfmd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step & res_valid),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: sv/lfmd_checker.sv
// Port-level checks of the uplink decoder, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lfmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// An error word must carry a zero byte and close the frame.
	logic err_word_ok;

	assign err_word_ok = !(m_tvalid && m_tuser[0]) || (m_tlast && m_tdata[7:0] == 8'd0);

	// The output word holds while the sink stalls.
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "word changed under stall")

	// Input is ready exactly when the output register is free.
	`ASSERT_ALWAYS(a_ready, clk, arst_n, s_tready == (!m_tvalid || m_tready), "ready mismatch")

	// A timeout word carries a zero byte and closes the frame.
	`ASSERT_ALWAYS(a_err, clk, arst_n, err_word_ok, "bad error word")

	// A start command never produces a word.
	`ASSERT_NEXT(a_start, clk, arst_n, s_tvalid && s_tready && s_tuser[0], m_tvalid == $past(m_tvalid && !m_tready), "word after start")

endmodule

bind lf_rfid_manchester_uplink_decoder lfmd_checker u_lfmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
